@@ rtl/hrm_pkg.sv @@
// ----------------------------------------------------------------------------
// hrm_pkg
// Shared constants and types of the histogram running median unit.
// ----------------------------------------------------------------------------
package hrm_pkg;

    localparam int VIEW_W  = 3;
    localparam int DIM_W   = 8;
    localparam int BIN_W   = 9;
    localparam int VAL_W   = 16;
    localparam int NB_W    = 10;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = 24;
    localparam int ADDR_W  = VIEW_W + DIM_W + BIN_W;
    localparam int VIEWS   = 1 << VIEW_W;
    localparam int DIMS    = 1 << DIM_W;
    localparam int BINS    = 1 << BIN_W;
    localparam int BIN_DEPTH = 1 << ADDR_W;
    localparam int SUM_W   = CNT_W + BIN_W + 1;
    localparam int EFF_W   = CNT_W + 1;
    localparam int DIVD_W  = 27;
    localparam int DIVS_W  = 16;
    localparam int DCNT_W  = 5;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam int PADDR_W = 4;
    localparam logic [PADDR_W-1:0] ADDR_MIN  = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_LEN  = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_BINS = 4'h8;

    localparam logic [VAL_W-1:0] MIN_RESET  = 16'd0;
    localparam logic [LEN_W-1:0] LEN_RESET  = 16'd256;
    localparam logic [NB_W-1:0]  BINS_RESET = 10'd300;

    localparam logic [1:0] MED_VAL    = 2'd0;
    localparam logic [1:0] MED_STORED = 2'd1;
    localparam logic [1:0] MED_CTR    = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] min_value;
        logic [LEN_W-1:0]        range_length;
        logic [NB_W-1:0]         bins_in_use;
    } cfg_t;

    typedef struct packed {
        logic       latch;
        logic       clear_small;
        logic       sweep_wr;
        logic       div_bin;
        logic       div_ctr;
        logic       bin_rd;
        logic       bin_wr;
        logic       med_rd;
        logic       scan_init;
        logic       scan_step;
        logic       med_ld;
        logic [1:0] med_sel;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic upd;
        logic div_done;
        logic eff_one;
        logic scan_hit;
        logic scan_end;
        logic sweep_last;
        logic out_busy;
    } status_t;

endpackage

@@ rtl/hrm_ram.sv @@
// ----------------------------------------------------------------------------
// hrm_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module hrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/hrm_div.sv @@
// ----------------------------------------------------------------------------
// hrm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hrm_pkg::DIVD_W-1:0]  dividend,
    input  logic [hrm_pkg::DIVS_W-1:0]  divisor,
    output logic                        done,
    output logic [hrm_pkg::DIVD_W-1:0]  quotient
);

    logic [hrm_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [hrm_pkg::DIVD_W-1:0] quo_reg, quo_next;
    logic [hrm_pkg::DIVS_W-1:0] dvs_reg;
    logic [hrm_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [hrm_pkg::DIVS_W:0]   trial;
    logic                       qbit;

    always_comb
    begin
        trial = {rem_reg, quo_reg[hrm_pkg::DIVD_W-1]};
        qbit  = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? hrm_pkg::DIVS_W'(trial - {1'b0, dvs_reg})
                            : trial[hrm_pkg::DIVS_W-1:0];
            quo_next = {quo_reg[hrm_pkg::DIVD_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == hrm_pkg::DCNT_W'(hrm_pkg::DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/hrm_datapath.sv @@
// ----------------------------------------------------------------------------
// hrm_datapath
// Histogram storage, binning, cumulative scan and median registers.
// ----------------------------------------------------------------------------
module hrm_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hrm_pkg::cfg_t        cfg,
    input  hrm_pkg::cmd_t        cmd,
    output hrm_pkg::status_t     status,
    input  logic [31:0]          in_tdata,
    input  logic                 in_tuser,
    input  logic                 in_tlast,
    output logic                 out_tvalid,
    input  logic                 out_tready,
    output logic [23:0]          out_tdata,
    output logic                 out_tlast
);

    logic                                 clr_reg;
    logic [hrm_pkg::VIEW_W-1:0]           view_reg;
    logic [hrm_pkg::DIM_W-1:0]            dim_reg;
    logic signed [hrm_pkg::VAL_W-1:0]     value_reg;
    logic                                 upd_reg;
    logic                                 fe_reg;
    logic [hrm_pkg::BIN_W-1:0]            idx_reg;
    logic [hrm_pkg::SUM_W-1:0]            sum_reg, sum_next;
    logic [hrm_pkg::BIN_W:0]              rj_reg;
    logic [hrm_pkg::BIN_W-1:0]            jd_reg;
    logic                                 acc_vld_reg;
    logic [hrm_pkg::ADDR_W-1:0]           sweep_reg;
    logic [hrm_pkg::CNT_W-1:0]            fc_reg [hrm_pkg::VIEWS];
    logic [hrm_pkg::DIMS-1:0]             med_vld_reg;
    logic signed [hrm_pkg::VAL_W-1:0]     med_reg, med_next;
    logic                                 out_vld_reg;
    logic [hrm_pkg::DIM_W-1:0]            out_dim_reg;
    logic [hrm_pkg::VAL_W-1:0]            out_med_reg;
    logic                                 out_last_reg;

    logic [hrm_pkg::NB_W-1:0]             nb;
    logic [hrm_pkg::LEN_W-1:0]            len;
    logic signed [hrm_pkg::VAL_W:0]       diff;
    logic [hrm_pkg::VAL_W-1:0]            diff_pos;
    logic [hrm_pkg::DIVD_W-1:0]           div_dvd;
    logic [hrm_pkg::DIVS_W-1:0]           div_dvs;
    logic                                 div_start;
    logic                                 div_done;
    logic [hrm_pkg::DIVD_W-1:0]           quo;
    logic [hrm_pkg::NB_W-1:0]             nb_m1;
    logic [hrm_pkg::BIN_W-1:0]            idx_clamp;
    logic [hrm_pkg::NB_W:0]               odd_j;
    logic [hrm_pkg::EFF_W-1:0]            eff;
    logic [hrm_pkg::EFF_W-1:0]            cutoff;
    logic [hrm_pkg::SUM_W-1:0]            acc_sum;
    logic                                 hit;
    logic                                 last_bin;
    logic signed [hrm_pkg::DIVD_W+1:0]    ctr;
    logic signed [hrm_pkg::VAL_W-1:0]     ctr_sat;
    logic signed [hrm_pkg::VAL_W-1:0]     stored;

    logic                                 bin_we, bin_re;
    logic [hrm_pkg::ADDR_W-1:0]           bin_waddr, bin_raddr;
    logic [hrm_pkg::CNT_W-1:0]            bin_wdata, bin_rdata;
    logic [hrm_pkg::VAL_W-1:0]            med_rdata;

    always_comb
    begin
        nb = cfg.bins_in_use;
        if (cfg.bins_in_use == '0)
        begin
            nb = hrm_pkg::NB_W'(1);
        end
        else if (cfg.bins_in_use > hrm_pkg::NB_W'(hrm_pkg::BINS))
        begin
            nb = hrm_pkg::NB_W'(hrm_pkg::BINS);
        end
        len = (cfg.range_length == '0) ? hrm_pkg::LEN_W'(1) : cfg.range_length;
        nb_m1 = nb - 1'b1;

        diff     = {value_reg[hrm_pkg::VAL_W-1], value_reg}
                 - {cfg.min_value[hrm_pkg::VAL_W-1], cfg.min_value};
        diff_pos = (diff > 0) ? diff[hrm_pkg::VAL_W-1:0] : '0;

        odd_j = {jd_reg, 1'b1} + (hrm_pkg::NB_W+1)'(0);
        if (cmd.div_ctr)
        begin
            div_dvd = hrm_pkg::DIVD_W'(odd_j) * hrm_pkg::DIVD_W'(len)
                    + hrm_pkg::DIVD_W'(nb);
            div_dvs = hrm_pkg::DIVS_W'({nb, 1'b0});
        end
        else
        begin
            div_dvd = hrm_pkg::DIVD_W'(diff_pos) * hrm_pkg::DIVD_W'(nb);
            div_dvs = len;
        end
        div_start = cmd.div_bin || cmd.div_ctr;

        idx_clamp = (quo > hrm_pkg::DIVD_W'(nb_m1)) ? nb_m1[hrm_pkg::BIN_W-1:0]
                                                   : quo[hrm_pkg::BIN_W-1:0];

        ctr = (hrm_pkg::DIVD_W+2)'(cfg.min_value) + (hrm_pkg::DIVD_W+2)'({1'b0, quo});
        ctr_sat = (ctr > (hrm_pkg::DIVD_W+2)'(32767)) ? 16'sd32767
                                                      : ctr[hrm_pkg::VAL_W-1:0];

        eff    = {1'b0, fc_reg[view_reg]} + hrm_pkg::EFF_W'(upd_reg);
        cutoff = hrm_pkg::EFF_W'(({1'b0, eff} + 1'b1) >> 1);

        acc_sum  = sum_reg + hrm_pkg::SUM_W'(bin_rdata);
        hit      = acc_sum > hrm_pkg::SUM_W'(cutoff);
        last_bin = {1'b0, jd_reg} == nb_m1;

        stored = med_vld_reg[dim_reg] ? med_rdata : '0;

        med_next = med_reg;
        if (cmd.med_ld)
        begin
            case (cmd.med_sel)
                hrm_pkg::MED_VAL:    med_next = value_reg;
                hrm_pkg::MED_STORED: med_next = stored;
                hrm_pkg::MED_CTR:    med_next = ctr_sat;
                default:             med_next = med_reg;
            endcase
        end

        sum_next = sum_reg;
        if (cmd.scan_init)
        begin
            sum_next = '0;
        end
        else if (cmd.scan_step && acc_vld_reg)
        begin
            sum_next = acc_sum;
        end

        bin_we    = cmd.sweep_wr || cmd.bin_wr;
        bin_waddr = cmd.sweep_wr ? sweep_reg : {view_reg, dim_reg, idx_reg};
        bin_wdata = '0;
        if (cmd.bin_wr)
        begin
            bin_wdata = (bin_rdata == hrm_pkg::COUNT_MAX) ? bin_rdata : bin_rdata + 1'b1;
        end
        bin_re    = cmd.bin_rd || cmd.scan_step;
        bin_raddr = cmd.bin_rd ? {view_reg, dim_reg, idx_clamp}
                               : {view_reg, dim_reg, rj_reg[hrm_pkg::BIN_W-1:0]};
    end

    hrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (quo)
    );

    hrm_ram #(
        .WIDTH (hrm_pkg::CNT_W),
        .DEPTH (hrm_pkg::BIN_DEPTH)
    ) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .re    (bin_re),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    hrm_ram #(
        .WIDTH (hrm_pkg::VAL_W),
        .DEPTH (hrm_pkg::DIMS)
    ) u_med_ram (
        .clk   (clk),
        .we    (cmd.finish),
        .waddr (dim_reg),
        .wdata (med_reg),
        .re    (cmd.med_rd),
        .raddr (dim_reg),
        .rdata (med_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg   <= '0;
            acc_vld_reg <= 1'b0;
            med_vld_reg <= '0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < hrm_pkg::VIEWS; i++)
            begin
                fc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.sweep_wr)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.scan_init)
            begin
                acc_vld_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                acc_vld_reg <= 1'b1;
            end
            if (cmd.clear_small)
            begin
                med_vld_reg <= '0;
                for (int i = 0; i < hrm_pkg::VIEWS; i++)
                begin
                    fc_reg[i] <= '0;
                end
            end
            else if (cmd.finish)
            begin
                med_vld_reg[dim_reg] <= 1'b1;
                if (fe_reg)
                begin
                    fc_reg[view_reg] <= (eff > hrm_pkg::EFF_W'(hrm_pkg::COUNT_MAX))
                                      ? hrm_pkg::COUNT_MAX : eff[hrm_pkg::CNT_W-1:0];
                end
            end
            if (cmd.finish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            clr_reg   <= in_tuser;
            view_reg  <= in_tdata[2:0];
            dim_reg   <= in_tdata[10:3];
            value_reg <= in_tdata[26:11];
            upd_reg   <= in_tdata[27];
            fe_reg    <= in_tlast;
        end
        if (cmd.bin_rd)
        begin
            idx_reg <= idx_clamp;
        end
        if (cmd.scan_init)
        begin
            rj_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            rj_reg <= rj_reg + 1'b1;
            jd_reg <= rj_reg[hrm_pkg::BIN_W-1:0];
        end
        sum_reg <= sum_next;
        med_reg <= med_next;
        if (cmd.finish)
        begin
            out_dim_reg  <= dim_reg;
            out_med_reg  <= med_reg;
            out_last_reg <= fe_reg;
        end
    end

    assign status.is_clear   = clr_reg;
    assign status.upd        = upd_reg;
    assign status.div_done   = div_done;
    assign status.eff_one    = eff == hrm_pkg::EFF_W'(1);
    assign status.scan_hit   = acc_vld_reg && hit;
    assign status.scan_end   = acc_vld_reg && !hit && last_bin;
    assign status.sweep_last = sweep_reg == {hrm_pkg::ADDR_W{1'b1}};
    assign status.out_busy   = out_vld_reg && !out_tready;

    assign out_tvalid = out_vld_reg;
    assign out_tdata  = {out_med_reg, out_dim_reg};
    assign out_tlast  = out_last_reg;

endmodule

@@ rtl/hrm_ctrl.sv @@
// ----------------------------------------------------------------------------
// hrm_ctrl
// Sequencer for request handling, histogram update, scan and clearing.
// ----------------------------------------------------------------------------
module hrm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_tvalid,
    output logic             in_tready,
    input  hrm_pkg::status_t status,
    output hrm_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_SWEEP = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DEC   = 4'd2;
    localparam logic [3:0] ST_DIVB  = 4'd3;
    localparam logic [3:0] ST_UPDR  = 4'd4;
    localparam logic [3:0] ST_UPDW  = 4'd5;
    localparam logic [3:0] ST_EVAL  = 4'd6;
    localparam logic [3:0] ST_SCAN  = 4'd7;
    localparam logic [3:0] ST_DIVC  = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_tready  = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (status.is_clear)
                begin
                    cmd.clear_small = 1'b1;
                    state_next      = ST_SWEEP;
                end
                else if (status.upd)
                begin
                    cmd.div_bin = 1'b1;
                    state_next  = ST_DIVB;
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_DIVB:
            begin
                if (status.div_done)
                begin
                    state_next = ST_UPDR;
                end
            end
            ST_UPDR:
            begin
                cmd.bin_rd = 1'b1;
                state_next = ST_UPDW;
            end
            ST_UPDW:
            begin
                cmd.bin_wr = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.med_rd = 1'b1;
                if (status.eff_one)
                begin
                    cmd.med_ld  = 1'b1;
                    cmd.med_sel = hrm_pkg::MED_VAL;
                    state_next  = ST_FIN;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_hit)
                begin
                    cmd.div_ctr = 1'b1;
                    state_next  = ST_DIVC;
                end
                else if (status.scan_end)
                begin
                    cmd.med_ld  = 1'b1;
                    cmd.med_sel = hrm_pkg::MED_STORED;
                    state_next  = ST_FIN;
                end
            end
            ST_DIVC:
            begin
                if (status.div_done)
                begin
                    cmd.med_ld  = 1'b1;
                    cmd.med_sel = hrm_pkg::MED_CTR;
                    state_next  = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/histogram_running_median_unit.sv @@
// Sequence: a request is decoded; with update, the divider finds its bin and the
//   count is read and written back; a bin scan follows unless the count is one,
//   and a divide on a hit. Throughput: one request at a time, set by the bin scan
//   over the count RAM read port and the one-bit-per-cycle divider.
// Reset and clear request: a clearing pass writes zero to all 1048576 count
//   entries, one per cycle, while no request is taken.
// ----------------------------------------------------------------------------
// histogram_running_median_unit
// Histogram-based running median per descriptor dimension.
// ----------------------------------------------------------------------------
module histogram_running_median_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // view, dim, value, update
    input  logic                         s_tuser,   // cmd
    input  logic                         s_tlast,   // frame_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // out_dim, median
    output logic                         m_tlast,   // out_last
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hrm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    hrm_pkg::cfg_t    cfg_reg;
    hrm_pkg::cmd_t    cmd;
    hrm_pkg::status_t status;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_value    <= hrm_pkg::MIN_RESET;
            cfg_reg.range_length <= hrm_pkg::LEN_RESET;
            cfg_reg.bins_in_use  <= hrm_pkg::BINS_RESET;
        end
        else if (wr_en)
        begin
            case (paddr)
                hrm_pkg::ADDR_MIN:  cfg_reg.min_value    <= pwdata[15:0];
                hrm_pkg::ADDR_LEN:  cfg_reg.range_length <= pwdata[15:0];
                hrm_pkg::ADDR_BINS: cfg_reg.bins_in_use  <= pwdata[9:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            hrm_pkg::ADDR_MIN:  prdata = {{16{cfg_reg.min_value[15]}}, cfg_reg.min_value};
            hrm_pkg::ADDR_LEN:  prdata = {16'd0, cfg_reg.range_length};
            hrm_pkg::ADDR_BINS: prdata = {22'd0, cfg_reg.bins_in_use};
            default:            prdata = '0;
        endcase
    end

    hrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_tvalid),
        .in_tready (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    hrm_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .status     (status),
        .in_tdata   (s_tdata),
        .in_tuser   (s_tuser),
        .in_tlast   (s_tlast),
        .out_tvalid (m_tvalid),
        .out_tready (m_tready),
        .out_tdata  (m_tdata),
        .out_tlast  (m_tlast)
    );

endmodule

@@ sim/histogram_running_median_checker.sv @@
// ----------------------------------------------------------------------------
// histogram_running_median_checker
// Watches the register port and both streams of the running median unit,
// keeps its own histograms, frame counts and stored medians, predicts the
// median of every sample request and compares each result against it.
// ----------------------------------------------------------------------------
module histogram_running_median_checker
    import hrm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [31:0]         s_tdata,   // view, dim, value, update
    input  logic                s_tuser,   // cmd
    input  logic                s_tlast,   // frame_end
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [23:0]         m_tdata,   // out_dim, median
    input  logic                m_tlast,   // out_last
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [DIM_W-1:0] out_dim;
        logic [VAL_W-1:0] median;
        logic             out_last;
    } median_res_t;

    logic [CNT_W-1:0] hist [int unsigned];
    logic [CNT_W-1:0] frame_cnt [VIEWS];
    logic [VAL_W-1:0] med_mem [DIMS];
    logic signed [VAL_W-1:0] cfg_min;
    logic [LEN_W-1:0] cfg_len;
    logic [NB_W-1:0]  cfg_bins;
    median_res_t      median_q [$];

    function automatic logic [CNT_W-1:0] hist_at(int unsigned a);
        if (hist.exists(a))
            return hist[a];
        return '0;
    endfunction

    task automatic clear_state();
        hist.delete();
        for (int i = 0; i < VIEWS; i++)
            frame_cnt[i] = '0;
        for (int i = 0; i < DIMS; i++)
            med_mem[i] = '0;
    endtask

    task automatic predict_median(logic [31:0] data, logic fe);
        logic [VIEW_W-1:0] v;
        logic [DIM_W-1:0]  d;
        logic signed [VAL_W-1:0] val;
        logic upd;
        longint nb, len, diff, idx, eff, cutoff, sum, off, c;
        int unsigned base;
        logic [VAL_W-1:0] med;
        median_res_t r;
        v    = data[2:0];
        d    = data[10:3];
        val  = data[26:11];
        upd  = data[27];
        nb   = (cfg_bins < 1) ? 1 : ((cfg_bins > BINS) ? BINS : cfg_bins);
        len  = (cfg_len == 0) ? 1 : cfg_len;
        base = ({v, d}) * BINS;
        if (upd)
        begin
            diff = longint'(val) - longint'(cfg_min);
            idx  = 0;
            if (diff > 0)
            begin
                idx = diff * nb / len;
                if (idx > nb - 1)
                    idx = nb - 1;
            end
            if (hist_at(base + idx) != COUNT_MAX)
                hist[base + idx] = hist_at(base + idx) + 1;
        end
        eff = longint'(frame_cnt[v]) + upd;
        med = med_mem[d];
        if (eff == 1)
            med = val;
        else
        begin
            cutoff = (eff + 1) / 2;
            sum    = 0;
            for (int j = 0; j < nb; j++)
            begin
                sum += hist_at(base + j);
                if (sum > cutoff)
                begin
                    off = ((2 * j + 1) * len + nb) / (2 * nb);
                    c   = longint'(cfg_min) + off;
                    if (c > 32767)
                        c = 32767;
                    med = c[VAL_W-1:0];
                    break;
                end
            end
        end
        med_mem[d] = med;
        if (fe)
            frame_cnt[v] = (eff > COUNT_MAX) ? COUNT_MAX : eff[CNT_W-1:0];
        r.out_dim  = d;
        r.median   = med;
        r.out_last = fe;
        median_q = {median_q, r};
    endtask

    initial
    begin
        fail_count = 0;
        cfg_min    = MIN_RESET;
        cfg_len    = LEN_RESET;
        cfg_bins   = BINS_RESET;
        clear_state();
    end

    assign pending = median_q.size();

    always @(posedge clk)
    begin
        median_res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (median_q.size() == 0)
                begin
                    $error("result with no request waiting: dim %0d median %0h",
                           m_tdata[7:0], m_tdata[23:8]);
                    fail_count++;
                end
                else
                begin
                    want = median_q.pop_front();
                    if (m_tdata[7:0] !== want.out_dim)
                    begin
                        $error("out_dim: expected %0d, actual %0d", want.out_dim, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[23:8] !== want.median)
                    begin
                        $error("median: expected %0h, actual %0h", want.median, m_tdata[23:8]);
                        fail_count++;
                    end
                    if (m_tlast !== want.out_last)
                    begin
                        $error("out_last: expected %0d, actual %0d", want.out_last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                    clear_state();
                else
                    predict_median(s_tdata, s_tlast);
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_MIN:  cfg_min  = pwdata[VAL_W-1:0];
                    ADDR_LEN:  cfg_len  = pwdata[LEN_W-1:0];
                    ADDR_BINS: cfg_bins = pwdata[NB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ sim/histogram_running_median_unit_test.sv @@
// ----------------------------------------------------------------------------
// histogram_running_median_unit_test
// Drives directed and random descriptor requests, clears and register
// settings into the running median unit under random stalls on both
// streams; a checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module histogram_running_median_unit_test;
    import hrm_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;   // view, dim, value, update
    logic               s_tuser;   // cmd
    logic               s_tlast;   // frame_end
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;   // out_dim, median
    logic               m_tlast;   // out_last
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 tx_idle;
    int                 rx_idle;
    int                 cycles;
    logic signed [VAL_W-1:0] cur_min;
    logic [LEN_W-1:0]        cur_len;

    histogram_running_median_unit dut (.*);

    histogram_running_median_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("histogram_running_median_unit_test failed");
            $finish;
        end
    end

    task automatic send_request(logic cmd, logic [2:0] view, logic [7:0] dim,
                                logic [15:0] value, logic upd, logic fe);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tlast  = fe;
        s_tdata  = {4'b0, upd, value, dim, view};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic reg_write(logic [PADDR_W-1:0] a, logic [31:0] d);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = a;
        pwdata  = d;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(logic [15:0] mn, logic [15:0] ln, logic [9:0] nb);
        drain();
        reg_write(ADDR_MIN, {16'b0, mn});
        reg_write(ADDR_LEN, {16'b0, ln});
        reg_write(ADDR_BINS, {22'b0, nb});
        cur_min = mn;
        cur_len = ln;
    endtask

    function automatic logic [15:0] pick_value();
        longint v;
        if ($urandom_range(99) < 30)
            return 16'($urandom_range(16'hFFFF));
        v = longint'(cur_min) + $urandom_range(cur_len);
        if (v > 32767)
            v = 32767;
        return v[15:0];
    endfunction

    task automatic random_traffic(int count, int start);
        int n;
        int run;
        logic [2:0] view;
        logic [7:0] dbase;
        n = 0;
        while (n < count)
        begin
            if (start + n < 200)
            begin
                tx_idle = 31;
                rx_idle = 56;
            end
            else if (start + n < 400)
            begin
                tx_idle = 56;
                rx_idle = 31;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            if (start + n == 300)
                send_request(1'b1, 3'($urandom), 8'($urandom), 16'($urandom),
                             1'($urandom), 1'($urandom));
            if (start + n == 450)
                drain();
            if ($urandom_range(99) < 10)
            begin
                send_request(1'b0, 3'($urandom), 8'($urandom), 16'($urandom),
                             1'($urandom), 1'($urandom));
                n++;
            end
            else
            begin
                view  = 3'($urandom);
                dbase = ($urandom_range(99) < 20) ? 8'($urandom) : 8'($urandom_range(3));
                run   = $urandom_range(1, 6);
                for (int k = 0; k < run; k++)
                begin
                    send_request(1'b0, view, 8'(dbase + $urandom_range(1)), pick_value(),
                                 $urandom_range(99) < 85, k == run - 1);
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        cycles   = 0;
        tx_idle  = 31;
        rx_idle  = 56;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cur_min  = MIN_RESET;
        cur_len  = LEN_RESET;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send_request(1'b0, 3'd0, 8'd0, 16'h0000, 1'b0, 1'b0);
        send_request(1'b0, 3'd0, 8'd0, 16'h0080, 1'b1, 1'b0);
        send_request(1'b0, 3'd0, 8'd1, 16'h8000, 1'b1, 1'b1);
        send_request(1'b0, 3'd0, 8'd1, 16'h7FFF, 1'b1, 1'b0);
        send_request(1'b0, 3'd0, 8'd1, 16'h7FFF, 1'b1, 1'b1);
        send_request(1'b0, 3'd0, 8'd1, 16'h0040, 1'b0, 1'b0);
        send_request(1'b0, 3'd7, 8'd255, 16'h7FFF, 1'b1, 1'b1);
        send_request(1'b0, 3'd7, 8'd255, 16'hFFFF, 1'b1, 1'b1);
        send_request(1'b0, 3'd7, 8'd255, 16'h0100, 1'b0, 1'b1);
        send_request(1'b0, 3'd5, 8'hAA, 16'h5555, 1'b1, 1'b0);
        send_request(1'b0, 3'd2, 8'h55, 16'hAAAA, 1'b0, 1'b0);
        send_request(1'b1, 3'd7, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
        send_request(1'b0, 3'd0, 8'd1, 16'h0020, 1'b0, 1'b0);
        send_request(1'b0, 3'd0, 8'd1, 16'h0020, 1'b1, 1'b1);

        set_config(16'h8000, 16'hFFFF, 10'd512);
        send_request(1'b0, 3'd1, 8'd3, 16'h8000, 1'b1, 1'b1);
        send_request(1'b0, 3'd1, 8'd3, 16'h7FFF, 1'b1, 1'b1);
        send_request(1'b0, 3'd1, 8'd3, 16'h7FFF, 1'b1, 1'b1);
        random_traffic(150, 0);

        set_config(16'h7FFF, 16'h0000, 10'd0);
        send_request(1'b0, 3'd2, 8'd9, 16'h8000, 1'b1, 1'b1);
        send_request(1'b0, 3'd2, 8'd9, 16'h7FFF, 1'b1, 1'b1);
        random_traffic(150, 150);

        set_config(16'hFF00, 16'h0200, 10'd1023);
        random_traffic(150, 300);

        set_config(16'hFE00, 16'h0400, 10'd16);
        random_traffic(150, 450);

        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("histogram_running_median_unit_test passed");
        else
            $display("histogram_running_median_unit_test failed");
        $finish;
    end

endmodule
